>>> rtl/gwm_pkg.sv
package gwm_pkg;

    // Pattern storage as seen on the configuration port.
    localparam int DEF_MAX_PATTERN = 48;
    localparam int CFG_WORDS       = 6;
    localparam int CFG_WORD_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int LEN_W           = 6;
    localparam int CHAR_W          = 8;

    // Register indexes. Pattern words take indexes 0 to 5.
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd6;

    localparam logic [CHAR_W-1:0] STAR_BYTE = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_BYTE  = 8'h3F;

    // Position vectors are handled at the widest legal size; unused bits stay zero.
    localparam int VEC_W       = 65;
    localparam int SCAN_LEVELS = 7;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              char_present;
        logic              last;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic take;
        logic take_last;
        logic fresh;
    } back_status_t;

    // Parallel prefix over (generate, propagate): bit j ends up set when some
    // bit i <= j generates and every bit above i up to j propagates. This
    // closes a position vector over runs of stars in log2 levels.
    function automatic logic [VEC_W-1:0] star_scan(input logic [VEC_W-1:0] gen,
                                                    input logic [VEC_W-1:0] prop);
        logic [VEC_W-1:0] g;
        logic [VEC_W-1:0] p;
        logic [VEC_W-1:0] g_n;
        logic [VEC_W-1:0] p_n;
        g = gen;
        p = prop;
        for (int lvl = 0; lvl < SCAN_LEVELS; lvl++) begin
            g_n = g;
            p_n = p;
            for (int j = (1 << lvl); j < VEC_W; j++) begin
                g_n[j] = g[j] | (p[j] & g[j - (1 << lvl)]);
                p_n[j] = p[j] & p[j - (1 << lvl)];
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

endpackage

>>> rtl/gwm_front.sv
module gwm_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic [0:0]            s_tuser,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  push,
    output gwm_pkg::item_t        push_item
);
    import gwm_pkg::*;

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    item_t f_item_next;
    logic  accept;

    assign push      = f_valid_reg && !q_full;
    assign push_item = f_item_reg;
    assign s_tready  = !f_valid_reg || !q_full;
    assign accept    = s_tvalid && s_tready;

    // Words with no byte that do not end the text change nothing and are dropped here.
    always_comb begin
        f_valid_next = f_valid_reg && !push;
        f_item_next  = f_item_reg;
        if (accept) begin
            f_valid_next            = s_tuser[0] || s_tlast;
            f_item_next.text_char    = s_tdata;
            f_item_next.char_present = s_tuser[0];
            f_item_next.last         = s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        f_item_reg <= f_item_next;
    end

endmodule

>>> rtl/gwm_queue.sv
module gwm_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  gwm_pkg::item_t          push_item,
    input  logic                    pop,
    output gwm_pkg::item_t          head_item,
    output gwm_pkg::queue_status_t  status
);
    import gwm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(do_push);
        rd_ptr_next = rd_ptr_reg + PTR_W'(do_pop);
        count_next  = count_reg + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/gwm_back.sv
module gwm_back #(
    parameter int MAX_PATTERN = gwm_pkg::DEF_MAX_PATTERN
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  gwm_pkg::item_t                       item,
    output logic                                 pop,
    input  logic [gwm_pkg::CHAR_W-1:0]           pat_byte [MAX_PATTERN],
    input  logic [MAX_PATTERN:0]                 in_use,
    input  logic [MAX_PATTERN:0]                 star_mask,
    input  logic [MAX_PATTERN:0]                 start_vec,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]     used_len,
    input  logic                                 reload,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic                                 matched,
    output gwm_pkg::back_status_t                status
);
    import gwm_pkg::*;

    logic [MAX_PATTERN:0] live_reg;
    logic [MAX_PATTERN:0] live_next;
    logic                 fresh_reg;
    logic                 fresh_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic                 m_matched_reg;
    logic                 m_matched_next;
    logic [MAX_PATTERN:0] cur_vec;
    logic [MAX_PATTERN:0] gen_vec;
    logic [VEC_W-1:0]     scan_vec;
    logic [MAX_PATTERN:0] step_vec;
    logic [MAX_PATTERN:0] end_vec;
    logic                 take;

    // While fresh, the live vector equals the start vector of the current pattern.
    assign cur_vec = fresh_reg ? start_vec : live_reg;
    assign take    = q_valid && (!item.last || !m_valid_reg || m_tready);
    assign pop     = take;

    always_comb begin
        gen_vec = '0;
        for (int j = 1; j <= MAX_PATTERN; j++) begin
            if (star_mask[j]) begin
                gen_vec[j] = cur_vec[j];
            end else if (in_use[j] && (pat_byte[j-1] == ANY_BYTE ||
                                        pat_byte[j-1] == item.text_char)) begin
                gen_vec[j] = cur_vec[j-1];
            end
        end
        scan_vec = star_scan(VEC_W'(gen_vec), VEC_W'(star_mask));
        step_vec = scan_vec[MAX_PATTERN:0];
        end_vec  = item.char_present ? step_vec : cur_vec;
    end

    always_comb begin
        live_next      = live_reg;
        fresh_next     = fresh_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_matched_next = m_matched_reg;
        if (take) begin
            live_next = end_vec;
            if (item.last) begin
                fresh_next     = 1'b1;
                m_valid_next   = 1'b1;
                m_matched_next = end_vec[used_len];
            end else begin
                fresh_next = 1'b0;
            end
        end
        if (reload) begin
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fresh_reg   <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
        live_reg      <= live_next;
        m_matched_reg <= m_matched_next;
    end

    assign m_tvalid         = m_valid_reg;
    assign matched          = m_matched_reg;
    assign status.take      = take;
    assign status.take_last = take && item.last;
    assign status.fresh     = fresh_reg;

endmodule

>>> rtl/glob_wildcard_matcher.sv
// Glob matcher for streamed text: '?' in the pattern matches any one byte, '*' matches
// any run of bytes including none, and every other pattern byte matches only itself
// (a pattern '*' is a wildcard even against a '*' in the text). Write the pattern bytes
// into registers 0 to 5 (byte 0 in the low bits of register 0) and the length into
// register 6; a length above MAX_PATTERN counts as MAX_PATTERN, and a write to index 0 to 6
// restarts matching. Text words carry one byte in s_tdata with s_tuser[0] set; a word with
// s_tuser[0] clear carries no byte, and s_tlast ends the text, so a lone word with
// s_tuser[0] clear and s_tlast set ends an empty text. Each text produces one result
// word whose bit 0 says whether the whole text matched the whole pattern. The block
// takes one word every clock cycle unless a result held on m_tready fills the queue; each
// byte moves a vector of live pattern positions in one step, closed over runs of stars by
// a seven level prefix network, and a queue between the input register and the matching
// stage keeps both sides running while a result waits on m_tready. Results are registered.
// No clearing pass follows reset.
module glob_wildcard_matcher #(
    parameter int MAX_PATTERN = gwm_pkg::DEF_MAX_PATTERN
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Text input.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] text_char
    input  logic [0:0]                      s_tuser,    // [0] char_present
    input  logic                            s_tlast,    // last
    // Match results.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,    // [0] matched, [7:1] zero
    // Configuration writes.
    input  logic                            cfg_wr_en,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [gwm_pkg::CFG_WORD_W-1:0]  cfg_wr_data
);
    import gwm_pkg::*;

    localparam int NLEN_W = $clog2(MAX_PATTERN + 1);

    logic [CFG_WORD_W-1:0] pat_reg [CFG_WORDS];
    logic [LEN_W-1:0]      len_reg;
    logic [CHAR_W-1:0]     pat_byte [MAX_PATTERN];
    logic [NLEN_W-1:0]     used_len;
    logic [MAX_PATTERN:0]  in_use;
    logic [MAX_PATTERN:0]  star_mask;
    logic [VEC_W-1:0]      start_scan;
    logic [MAX_PATTERN:0]  start_vec;
    logic                  reload;

    logic          push;
    item_t         push_item;
    item_t         head_item;
    queue_status_t q_status;
    back_status_t  b_status;
    logic          pop;
    logic          matched;

    // Configuration registers. Indexes past the length register are ignored.
    assign reload = cfg_wr_en && (cfg_wr_index <= REG_LENGTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < CFG_WORDS; w++) begin
                pat_reg[w] <= '0;
            end
            len_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index <= REG_CHARS_LAST) begin
                pat_reg[cfg_wr_index] <= cfg_wr_data;
            end else if (cfg_wr_index == REG_LENGTH) begin
                len_reg <= cfg_wr_data[LEN_W-1:0];
            end
        end
    end

    // Pattern decode. Bytes past the register file read as zero.
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_pat
            if (k < CFG_WORDS * 8) begin : g_stored
                assign pat_byte[k] = pat_reg[k / 8][(k % 8) * 8 +: 8];
            end else begin : g_zero
                assign pat_byte[k] = '0;
            end
            assign in_use[k+1]    = (k < int'(used_len));
            assign star_mask[k+1] = in_use[k+1] && (pat_byte[k] == STAR_BYTE);
        end
    endgenerate

    assign in_use[0]    = 1'b1;
    assign star_mask[0] = 1'b0;
    assign used_len     = (int'(len_reg) > MAX_PATTERN) ? NLEN_W'(MAX_PATTERN)
                                                        : NLEN_W'(len_reg);

    // Start vector: position zero, then closed over any leading stars.
    assign start_scan = star_scan(VEC_W'(1), VEC_W'(star_mask));
    assign start_vec  = start_scan[MAX_PATTERN:0];

    gwm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .q_full    (q_status.full),
        .push      (push),
        .push_item (push_item)
    );

    gwm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    gwm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (!q_status.empty),
        .item      (head_item),
        .pop       (pop),
        .pat_byte  (pat_byte),
        .in_use    (in_use),
        .star_mask (star_mask),
        .start_vec (start_vec),
        .used_len  (used_len),
        .reload    (reload),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .matched   (matched),
        .status    (b_status)
    );

    assign m_tdata = {7'b0, matched};

    // The queue can never report full and empty together.
    a_queue_state: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty at once");

    // A result only appears after the matching stage takes a word that ends a text.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !b_status.take_last) |=> !m_tvalid)
        else $error("result word appeared without an ending text word");

    // A register write always restarts matching from the start vector.
    a_cfg_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        reload |=> b_status.fresh)
        else $error("configuration write did not restart matching");

    // The matching stage never takes a word from an empty queue.
    a_take_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        b_status.take |-> !q_status.empty)
        else $error("matching stage took a word from an empty queue");

endmodule
